@@ rtl/core/headtracker_frame_decoder_defines.svh @@
// Assertion macros shared by the head-tracker frame decoder RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef HEADTRACKER_FRAME_DECODER_DEFINES_SVH
`define HEADTRACKER_FRAME_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define HFD_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("headtracker frame decoder assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define HFD_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("headtracker frame decoder assertion failed");
`else
`define HFD_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define HFD_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

@@ rtl/core/hfd_pkg.sv @@
// Package for the head-tracker frame decoder: constants, codes, types and the CRC step.
// Has no dependencies; every RTL module of the block refers to it by scoped names.
`default_nettype none

package hfd_pkg;

  // Window and frame layout.
  localparam int          WIN_LEN  = 10;
  localparam logic [7:0]  SYNC0    = 8'hA5;
  localparam logic [7:0]  SYNC1    = 8'h5A;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Angle to pulse width mapping: centre + angle * gain / 2^11, then clamp.
  localparam logic signed [9:0]  PULSE_GAIN   = 10'sd500;
  localparam logic signed [20:0] DIV_BIAS     = 21'sd2047;
  localparam logic signed [11:0] PULSE_CENTRE = 12'sd1500;
  localparam logic signed [11:0] PULSE_MIN    = 12'sd1000;
  localparam logic signed [11:0] PULSE_MAX    = 12'sd2000;

  // Highest valid one-based channel number.
  localparam logic [4:0] CHAN_MAX = 5'd16;

  // Frame queue in front of the output register.
  localparam int FRAME_SLOTS = 2;
  localparam int SLOT_AW     = 1;
  localparam int SLOT_CW     = 2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_YAW    = 2'd1,
    REG_PITCH  = 2'd2,
    REG_ROLL   = 2'd3
  } hfd_reg_t;

  // Source axis of an override, in emission order.
  typedef enum logic [1:0] {
    AXIS_YAW   = 2'd0,
    AXIS_PITCH = 2'd1,
    AXIS_ROLL  = 2'd2
  } hfd_axis_t;

  // One decoded frame: which axes still owe an override, and their pulse widths.
  typedef struct packed {
    logic [2:0]       mask;
    logic [2:0][10:0] pw;
  } hfd_frame_t;

  // Advance a CRC-16 (poly 0x1021, MSB first) by one byte.
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hfd_cell.sv @@
// One cell of the receive window: a byte and the running CRC from that byte to the newest one.
// Depends on hfd_pkg for the CRC step.
`default_nettype none

module hfd_cell (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        shift,
  input  wire logic        clear,
  input  wire logic [7:0]  byte_in,
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  rx_byte,
  output logic [7:0]       win_byte,
  output logic [15:0]      win_crc
);

  logic [15:0] crc_next;

  // The neighbour's CRC covers every byte after this one; fold in the arriving byte.
  always_comb begin
    crc_next = hfd_pkg::crc_update(crc_in, rx_byte);
  end

  // A cleared window holds zero bytes, whose CRC with a zero start is zero too.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      win_byte <= '0;
      win_crc  <= '0;
    end else if (shift) begin
      win_byte <= byte_in;
      win_crc  <= crc_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hfd_pulse.sv @@
// Two-stage angle to pulse width converter: multiply, then divide by 2048, offset and clamp.
// Depends on hfd_pkg for the mapping constants.
`default_nettype none

module hfd_pulse (
  input  wire logic        clk,
  input  wire logic [11:0] angle,
  output logic [10:0]      pw
);

  logic signed [21:0] prod_full;
  logic signed [20:0] prod;
  logic signed [20:0] biased;
  logic signed [9:0]  quot;
  logic signed [11:0] width;
  logic signed [11:0] width_clamped;

  // Stage one: signed product, which always fits 21 bits.
  assign prod_full = $signed(angle) * hfd_pkg::PULSE_GAIN;

  always_ff @(posedge clk) begin
    prod <= prod_full[20:0];
  end

  // Stage two: shift with a bias so that negative values round toward zero.
  always_comb begin
    biased = prod + (prod[20] ? hfd_pkg::DIV_BIAS : 21'sd0);
    quot   = biased[20:11];
    width  = {{2{quot[9]}}, quot} + hfd_pkg::PULSE_CENTRE;
    if (width < hfd_pkg::PULSE_MIN) begin
      width_clamped = hfd_pkg::PULSE_MIN;
    end else if (width > hfd_pkg::PULSE_MAX) begin
      width_clamped = hfd_pkg::PULSE_MAX;
    end else begin
      width_clamped = width;
    end
  end

  always_ff @(posedge clk) begin
    pw <= width_clamped[10:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/hfd_emit.sv @@
// Frame queue and output register: walks each decoded frame's axes and sends one override a beat.
// Depends on hfd_pkg for the frame type, axis codes and queue sizes, and on the assertion macros.
`default_nettype none
`include "headtracker_frame_decoder_defines.svh"

module hfd_emit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire hfd_pkg::hfd_frame_t        frame_in,
  input  wire logic [2:0][4:0]            chan_cfg,
  output logic [hfd_pkg::SLOT_CW-1:0]     count,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // m_axis_tdata: channel_index [3:0], axis [5:4], pulse_width [16:6], zeros above
  output logic [23:0]                     m_axis_tdata,
  output logic                            m_axis_tlast
);

  hfd_pkg::hfd_frame_t               slot [hfd_pkg::FRAME_SLOTS];
  logic [hfd_pkg::SLOT_AW-1:0]       wr_ptr;
  logic [hfd_pkg::SLOT_AW-1:0]       rd_ptr;
  logic [2:0]                        head_mask;
  logic [2:0]                        remaining;
  hfd_pkg::hfd_axis_t                sel;
  logic                              last_sel;
  logic                              load;
  logic                              pop;
  logic [4:0]                        chan_sel;

  function automatic logic [hfd_pkg::SLOT_CW-1:0] SLOT_CW_ONE(input logic bit_in);
    return {{(hfd_pkg::SLOT_CW-1){1'b0}}, bit_in};
  endfunction

  // Pick the lowest pending axis of the head frame: yaw, then pitch, then roll.
  always_comb begin
    head_mask = slot[rd_ptr].mask;
    priority if (head_mask[0]) begin
      sel = hfd_pkg::AXIS_YAW;
    end else if (head_mask[1]) begin
      sel = hfd_pkg::AXIS_PITCH;
    end else begin
      sel = hfd_pkg::AXIS_ROLL;
    end
    remaining = head_mask & ~(3'd1 << sel);
    last_sel  = (remaining == 3'd0);
    chan_sel  = chan_cfg[sel];
    load      = (count != '0) && (!m_axis_tvalid || m_axis_tready);
    pop       = load && last_sel;
  end

  // Queue control and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + SLOT_CW_ONE(push) - SLOT_CW_ONE(pop);
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Frame slots and the output beat. The slot being filled is never the head being drained.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= frame_in;
    end
    if (load) begin
      slot[rd_ptr].mask <= remaining;
      m_axis_tdata      <= {7'd0, slot[rd_ptr].pw[sel], sel, 4'(chan_sel - 5'd1)};
      m_axis_tlast      <= last_sel;
    end
  end

  `HFD_ASSERT_IMPLIES(a_queue_room, clk, rst, push,
    count < hfd_pkg::SLOT_CW'(hfd_pkg::FRAME_SLOTS))
  `HFD_ASSERT_IMPLIES(a_head_pending, clk, rst, count != '0, head_mask != 3'd0)
  `HFD_ASSERT_NEXT(a_frame_continues, clk, rst, load && !last_sel, count != '0)

endmodule

`default_nettype wire

@@ rtl/core/headtracker_frame_decoder.sv @@
// Head-tracker frame decoder: throughput one received byte per cycle while s_axis_tready is high.
// An override beat follows the byte completing a frame through the angle capture at the edge that
// accepts it, then the multiply and divide stages, the frame queue and the output register.
// Up to three beats follow, one per cycle while m_axis_tready is high; input stalls only while
// two frames sit in the converter stages or the frame queue. Reset (rst, synchronous, active
// high) clears the window, queue and valids, enables the tracker and marks all channels unused.
`default_nettype none
`include "headtracker_frame_decoder_defines.svh"

module headtracker_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // s_axis_tdata: rx_byte [7:0]
  input  wire logic [7:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // m_axis_tdata: channel_index [3:0], axis [5:4], pulse_width [16:6], zeros above
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);

  localparam int N = hfd_pkg::WIN_LEN;

  logic        tracker_enabled;
  logic [4:0]  yaw_channel;
  logic [4:0]  pitch_channel;
  logic [4:0]  roll_channel;

  logic [7:0]  chain_byte [N+1];
  logic [15:0] chain_crc  [N+1];
  logic [15:0] crc0_next;
  logic        in_take;
  logic        hit;

  logic        s1_valid;
  logic        s2_valid;
  logic        s3_valid;
  logic [11:0] s1_roll;
  logic [11:0] s1_tilt;
  logic [11:0] s1_pan;
  logic [10:0] pw_pan;
  logic [10:0] pw_tilt;
  logic [10:0] pw_roll;

  hfd_pkg::hfd_frame_t             frame_in;
  logic                            frame_push;
  logic [2:0][4:0]                 chan_cfg;
  logic [hfd_pkg::SLOT_CW-1:0]     q_count;
  logic [2:0]                      frames_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tracker_enabled <= 1'b1;
      yaw_channel     <= '0;
      pitch_channel   <= '0;
      roll_channel    <= '0;
    end else if (cfg_we) begin
      unique case (hfd_pkg::hfd_reg_t'(cfg_index))
        hfd_pkg::REG_ENABLE: tracker_enabled <= cfg_data[0];
        hfd_pkg::REG_YAW:    yaw_channel     <= cfg_data;
        hfd_pkg::REG_PITCH:  pitch_channel   <= cfg_data;
        hfd_pkg::REG_ROLL:   roll_channel    <= cfg_data;
      endcase
    end
  end

  // Input handshake: room is kept for every frame that could still reach the queue.
  assign frames_busy   = {2'b0, s1_valid} + {2'b0, s2_valid} + {2'b0, s3_valid}
                       + {1'b0, q_count};
  assign s_axis_tready = frames_busy < 3'(hfd_pkg::FRAME_SLOTS);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // The window: each cell takes its neighbour's byte; the newest byte enters at the tail.
  assign chain_byte[N] = s_axis_tdata;
  assign chain_crc[N]  = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    hfd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (in_take),
      .clear    (hit),
      .byte_in  (chain_byte[k+1]),
      .crc_in   (chain_crc[k+1]),
      .rx_byte  (s_axis_tdata),
      .win_byte (chain_byte[k]),
      .win_crc  (chain_crc[k])
    );
  end

  // Frame check on the shifted window: sync bytes in front and a zero CRC residue
  // over all ten bytes, which holds exactly when the trailing CRC matches.
  always_comb begin
    crc0_next = hfd_pkg::crc_update(chain_crc[1], s_axis_tdata);
    hit       = in_take && (chain_byte[1] == hfd_pkg::SYNC0)
                        && (chain_byte[2] == hfd_pkg::SYNC1)
                        && (crc0_next == 16'h0000);
  end

  // Capture the three angles from window bytes three to seven.
  always_ff @(posedge clk) begin
    if (hit) begin
      s1_roll <= {chain_byte[5], chain_byte[4][7:4]};
      s1_tilt <= {chain_byte[7][3:0], chain_byte[6]};
      s1_pan  <= {chain_byte[8], chain_byte[7][7:4]};
    end
  end

  // Frame valid follows the two converter stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= hit;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  hfd_pulse u_pulse_pan  (.clk(clk), .angle(s1_pan),  .pw(pw_pan));
  hfd_pulse u_pulse_tilt (.clk(clk), .angle(s1_tilt), .pw(pw_tilt));
  hfd_pulse u_pulse_roll (.clk(clk), .angle(s1_roll), .pw(pw_roll));

  // Assemble the frame; an axis is pending when enabled and its channel is in range.
  always_comb begin
    frame_in.pw[hfd_pkg::AXIS_YAW]   = pw_pan;
    frame_in.pw[hfd_pkg::AXIS_PITCH] = pw_tilt;
    frame_in.pw[hfd_pkg::AXIS_ROLL]  = pw_roll;
    frame_in.mask[hfd_pkg::AXIS_YAW]   = tracker_enabled && (yaw_channel != 5'd0)
                                      && (yaw_channel <= hfd_pkg::CHAN_MAX);
    frame_in.mask[hfd_pkg::AXIS_PITCH] = tracker_enabled && (pitch_channel != 5'd0)
                                      && (pitch_channel <= hfd_pkg::CHAN_MAX);
    frame_in.mask[hfd_pkg::AXIS_ROLL]  = tracker_enabled && (roll_channel != 5'd0)
                                      && (roll_channel <= hfd_pkg::CHAN_MAX);
    frame_push = s3_valid && (frame_in.mask != 3'd0);
    chan_cfg[hfd_pkg::AXIS_YAW]   = yaw_channel;
    chan_cfg[hfd_pkg::AXIS_PITCH] = pitch_channel;
    chan_cfg[hfd_pkg::AXIS_ROLL]  = roll_channel;
  end

  hfd_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .push          (frame_push),
    .frame_in      (frame_in),
    .chan_cfg      (chan_cfg),
    .count         (q_count),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `HFD_ASSERT_IMPLIES(a_window_cleared, clk, rst, s1_valid,
    (chain_byte[0] == 8'h00) && (chain_crc[0] == 16'h0000))
  `HFD_ASSERT_IMPLIES(a_one_frame_in_flight, clk, rst, 1'b1,
    $countones({s1_valid, s2_valid, s3_valid}) <= 1)
  `HFD_ASSERT_NEXT(a_frame_reaches_converter, clk, rst, s1_valid, s2_valid && !s1_valid)

endmodule

`default_nettype wire
